>>> hdl/hcbd_pkg.sv
// Shared constants and types for the chunked body decoder.
// No dependencies; imported by the core and its checker.
`default_nettype none

package hcbd_pkg;

    // Characters that drive the size-line parser
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    // End-of-body status codes
    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_STOPPED  = 2'd1,
        ST_FAILED   = 2'd2
    } t_status;

endpackage : hcbd_pkg

`default_nettype wire

>>> hdl/http_chunked_body_decoder_core.sv
// HTTP/1.1 chunked body decoder core: parses size lines, passes payload bytes.
// Depends on hcbd_pkg (character constants, status codes).
//
//  channel | direction | handshake                | fields
//  --------+-----------+--------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_byte, i_in_last
//  out     | output    | o_out_valid / i_out_stall| o_out_byte, o_out_is_data,
//          |           |                          | o_out_done, o_out_status
//
// One byte per cycle while o_in_stall is low: the parser state updates in the cycle a byte is taken, and
// the result is registered in that same cycle into the output register, or into the skid entry on stall.
// A one-entry skid buffer lets a new byte enter while a result waits on stall;
// o_in_stall rises only once the skid entry is full.
// Reset (synchronous, active low) clears the parser and the valid flags of both output stages.
// After a byte with i_in_last the parser returns to its reset state.
`default_nettype none

module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_is_data,
    output logic            o_out_done,
    output logic [1:0]      o_out_status
);

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_DIGITS  = 4'd1,
        PH_TRAIL   = 4'd2,
        PH_EXT     = 4'd3,
        PH_DATA    = 4'd4,
        PH_DATA_CR = 4'd5,
        PH_DATA_LF = 4'd6,
        PH_DONE    = 4'd7,
        PH_STOP    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       done;
        logic [1:0] status;
    } t_result;

    // Parser state
    t_phase                 r_phase,   n_phase;
    logic [SIZE_BITS-1:0]   r_rem,     n_rem;
    logic                   r_seen,    n_seen;
    logic                   r_pend_cr, n_pend_cr;
    logic                   r_any,     n_any;

    // Output register and skid entry
    logic                   r_out_valid;
    t_result                r_out;
    logic                   r_skid_valid;
    t_result                r_skid;

    // Per-byte decode
    logic                   accept;
    logic                   take;
    logic                   res_valid;
    t_result                res;
    logic                   is_ws;
    logic                   hex_ok;
    logic [3:0]             hex_val;
    logic                   skip_rest;
    t_phase                 ph;
    logic [SIZE_BITS-1:0]   rem_dec;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign take       = r_out_valid && !i_out_stall;
    assign rem_dec    = r_rem - SIZE_BITS'(1);

    // Character classes
    always_comb begin
        is_ws = (i_in_byte == CHAR_SPACE) ||
                ((i_in_byte >= CHAR_TAB) && (i_in_byte <= CHAR_CR));
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if ((i_in_byte >= 8'h30) && (i_in_byte <= 8'h39)) begin
            hex_val = 4'(i_in_byte - 8'h30);
        end else if ((i_in_byte >= 8'h61) && (i_in_byte <= 8'h66)) begin
            hex_val = 4'(i_in_byte - 8'h57);
        end else if ((i_in_byte >= 8'h41) && (i_in_byte <= 8'h46)) begin
            hex_val = 4'(i_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Next parser state and result for the byte on the input
    always_comb begin
        n_rem     = r_rem;
        n_seen    = r_seen;
        n_pend_cr = r_pend_cr;
        n_any     = r_any;
        ph        = r_phase;
        skip_rest = 1'b0;
        res       = '0;

        unique case (r_phase)
            PH_LEAD, PH_DIGITS, PH_TRAIL, PH_EXT: begin
                // CR held over from the previous byte: CRLF ends the line,
                // otherwise the CR was whitespace
                if (r_pend_cr) begin
                    n_pend_cr = 1'b0;
                    if (i_in_byte == CHAR_LF) begin
                        skip_rest = 1'b1;
                        n_seen    = 1'b0;
                        if (!r_seen) begin
                            ph = PH_STOP;
                        end else if (r_rem == '0) begin
                            ph = PH_DONE;
                        end else begin
                            ph = PH_DATA;
                        end
                    end else if (ph == PH_DIGITS) begin
                        ph = PH_TRAIL;
                    end
                end
                if (!skip_rest) begin
                    if (i_in_byte == CHAR_CR) begin
                        n_pend_cr = 1'b1;
                    end else if (ph == PH_EXT) begin
                        // extension text is discarded up to the line end
                    end else if (is_ws) begin
                        if (ph == PH_DIGITS) begin
                            ph = PH_TRAIL;
                        end
                    end else if (i_in_byte == CHAR_SEMI) begin
                        ph = r_seen ? PH_EXT : PH_STOP;
                    end else if (ph == PH_TRAIL) begin
                        ph = PH_STOP;
                    end else if (!hex_ok || (|r_rem[SIZE_BITS-1 -: 4])) begin
                        // bad digit or size overflow
                        ph = PH_STOP;
                    end else begin
                        n_rem  = {r_rem[SIZE_BITS-5:0], hex_val};
                        n_seen = 1'b1;
                        ph     = PH_DIGITS;
                    end
                end
            end
            PH_DATA: begin
                res.is_data   = 1'b1;
                res.data_byte = i_in_byte;
                n_any         = 1'b1;
                n_rem         = rem_dec;
                if (rem_dec == '0) begin
                    ph = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                ph = (i_in_byte == CHAR_CR) ? PH_DATA_LF : PH_STOP;
            end
            PH_DATA_LF: begin
                ph    = (i_in_byte == CHAR_LF) ? PH_LEAD : PH_STOP;
                n_rem = '0;
            end
            PH_DONE: begin
            end
            default: begin
                ph = PH_STOP;
            end
        endcase

        n_phase = ph;

        // Last byte: report status and return to reset state
        if (i_in_last) begin
            res.done = 1'b1;
            if (ph == PH_DONE) begin
                res.status = ST_COMPLETE;
            end else if (n_any) begin
                res.status = ST_STOPPED;
            end else begin
                res.status = ST_FAILED;
            end
            n_phase   = PH_LEAD;
            n_rem     = '0;
            n_seen    = 1'b0;
            n_pend_cr = 1'b0;
            n_any     = 1'b0;
        end

        res_valid = accept && (res.is_data || i_in_last);
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEAD;
            r_rem     <= '0;
            r_seen    <= 1'b0;
            r_pend_cr <= 1'b0;
            r_any     <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_rem     <= n_rem;
            r_seen    <= n_seen;
            r_pend_cr <= n_pend_cr;
            r_any     <= n_any;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out.data_byte;
    assign o_out_is_data = r_out.is_data;
    assign o_out_done    = r_out.done;
    assign o_out_status  = r_out.status;

endmodule : http_chunked_body_decoder_core

`default_nettype wire

>>> hdl/hcbd_checker.sv
// Port-level checker for the chunked body decoder core, bound to the core module.
// Depends on hcbd_pkg (status codes).
`default_nettype none

module hcbd_checker
    import hcbd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_out_is_data,
    input wire logic       o_out_done,
    input wire logic [1:0] o_out_status
);

    // A result carries a payload byte, a status, or both
    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_is_data || o_out_done))
        else $error("result with neither data nor done");

    // Status is zero except on the last transaction of a body
    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_done) |-> (o_out_status == ST_COMPLETE))
        else $error("status set without done");

    // Byte field is zero when no payload is carried
    a_byte_zero_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_is_data) |-> (o_out_byte == 8'h00))
        else $error("byte field set without data");

    // A body that fails with nothing decoded cannot end on a payload byte
    a_failed_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_done && (o_out_status == ST_FAILED)) |-> !o_out_is_data)
        else $error("failed status on a data transaction");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_out_is_data) &&
             $stable(o_out_done) && $stable(o_out_status)))
        else $error("stalled result changed");

endmodule : hcbd_checker

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (.*);

`default_nettype wire
